### src/tsr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tsr_pkg
// Shared types, widths and helpers of the scanline triangle rasterizer.
// ============================================================================
package tsr_pkg;

    localparam int X_W          = 10;
    localparam int Y_W          = 9;
    localparam int COL_W        = 8;
    localparam int FRAC_W       = 16;
    localparam int EDGE_W       = 32;
    localparam int SCREEN_WIDTH = 640;
    localparam int DX_W         = X_W + 1;
    localparam int NUM_W        = 30;
    localparam int MAG_W        = NUM_W - 1;
    localparam int DEN_W        = Y_W + 2;
    localparam int CNT_W        = $clog2(MAG_W);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [X_W-1:0]   ax;
        logic [Y_W-1:0]   ay;
        logic [X_W-1:0]   bx;
        logic [Y_W-1:0]   by_coord;
        logic [X_W-1:0]   cx;
        logic [Y_W-1:0]   cy;
        logic [COL_W-1:0] fill_colour;
    } in_item_t;

    typedef struct packed {
        logic [Y_W-1:0]   span_row;
        logic [X_W-1:0]   span_left;
        logic [X_W-1:0]   span_right;
        logic [COL_W-1:0] span_colour;
        logic             span_valid;
        logic             last_span;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_UPPER,
        PH_LOWER
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FB,
        KIND_FT,
        KIND_SPLIT_UP,
        KIND_SPLIT_LO
    } kind_t;

    typedef enum logic [1:0] {
        JOB_SPLIT,
        JOB_SLOPE1,
        JOB_SLOPE2
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SPLIT_START,
        ST_SPLIT_WAIT,
        ST_S1_START,
        ST_S1_WAIT,
        ST_S2_START,
        ST_S2_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic step;
        logic div_start;
        job_t div_job;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic is_split;
        logic enter_lower;
        logic div_done;
        logic out_free;
    } status_t;

    // Signed difference of two unsigned coordinates.
    function automatic logic signed [DX_W-1:0] xdiff(input logic [X_W-1:0] a,
                                                     input logic [X_W-1:0] b);
        xdiff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Floor of a fixed-point edge, clamped to the screen.
    function automatic logic [X_W-1:0] span_x(input logic signed [EDGE_W-1:0] e);
        logic signed [EDGE_W-FRAC_W-1:0] whole;
        whole = e[EDGE_W-1:FRAC_W];
        if (whole < 0)
            span_x = '0;
        else if (whole > (EDGE_W-FRAC_W)'(SCREEN_WIDTH - 1))
            span_x = X_W'(SCREEN_WIDTH - 1);
        else
            span_x = whole[X_W-1:0];
    endfunction

endpackage

### src/triangle_scanline_rasterizer.sv
`timescale 1ns / 1ps
// ============================================================================
// triangle_scanline_rasterizer
// Flat-top / flat-bottom scanline triangle fill producing one span per step.
// ============================================================================
// A load transfer sorts the three vertices, then runs one serial division per
// edge slope, one quotient bit per cycle, plus another division for the split
// point when the triangle has no flat edge; no new transfer is taken until
// these finish. Reaching the middle row of a split triangle reruns the two
// slope divisions before the next transfer. Any other step transfer is taken
// while the previous span still waits in the output register as long as that
// span is taken in that same cycle.
module triangle_scanline_rasterizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsr_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tsr_pkg::out_item_t  out_data
);

    tsr_pkg::cmd_t    cmd;
    tsr_pkg::status_t status;

    tsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (in_data.opcode),
        .status   (status),
        .cmd      (cmd)
    );

    tsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### src/tsr_div.sv
`timescale 1ns / 1ps
// ============================================================================
// tsr_div
// Serial restoring divider, one quotient bit per cycle, floor rounding.
// ============================================================================
module tsr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                neg,
    input  logic [tsr_pkg::MAG_W-1:0]           mag,
    input  logic [tsr_pkg::DEN_W-1:0]           den,
    output logic                                done,
    output logic signed [tsr_pkg::EDGE_W-1:0]   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tsr_pkg::CNT_W-1:0]     cnt_reg;
    logic [tsr_pkg::DEN_W:0]       rem_reg;
    logic [tsr_pkg::MAG_W-1:0]     quo_reg;
    logic [tsr_pkg::DEN_W-1:0]     den_reg;
    logic                          neg_reg;

    logic [tsr_pkg::DEN_W:0]       rem_shift;
    logic                          fits;
    logic signed [tsr_pkg::EDGE_W-1:0] q_ext;

    assign rem_shift = {rem_reg[tsr_pkg::DEN_W-1:0], quo_reg[tsr_pkg::MAG_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tsr_pkg::CNT_W'(tsr_pkg::MAG_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= mag;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quo_reg <= {quo_reg[tsr_pkg::MAG_W-2:0], fits};
        end
    end

    // A negative dividend rounds toward minus infinity when a remainder is left.
    always_comb
    begin
        q_ext = $signed(tsr_pkg::EDGE_W'(quo_reg));
        if (den_reg == '0)
            quotient = '0;
        else if (neg_reg)
            quotient = -q_ext - ((rem_reg != '0) ? 1 : 0);
        else
            quotient = q_ext;
    end

    assign done = done_reg;

endmodule

### src/tsr_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// tsr_datapath
// Vertex, edge and slope registers, the divider and the span output register.
// ============================================================================
module tsr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tsr_pkg::in_item_t   in_data,
    input  tsr_pkg::cmd_t       cmd,
    output tsr_pkg::status_t    status,
    output logic                out_valid,
    input  logic                out_ready,
    output tsr_pkg::out_item_t  out_data
);

    logic [tsr_pkg::X_W-1:0]           vx_reg [3];
    logic [tsr_pkg::Y_W-1:0]           vy_reg [3];
    logic [tsr_pkg::X_W-1:0]           split_x_reg;
    logic signed [tsr_pkg::EDGE_W-1:0] edge_l_reg;
    logic signed [tsr_pkg::EDGE_W-1:0] edge_r_reg;
    logic signed [tsr_pkg::EDGE_W-1:0] slope1_reg;
    logic signed [tsr_pkg::EDGE_W-1:0] slope2_reg;
    logic [tsr_pkg::Y_W-1:0]           cur_row_reg;
    logic [tsr_pkg::Y_W-1:0]           end_row_reg;
    logic [tsr_pkg::COL_W-1:0]         colour_reg;
    tsr_pkg::phase_t                   phase_reg;
    tsr_pkg::kind_t                    kind_reg;
    logic                              out_valid_reg;
    tsr_pkg::out_item_t                out_data_reg;

    logic [tsr_pkg::X_W-1:0]           sx [3];
    logic [tsr_pkg::Y_W-1:0]           sy [3];
    logic [tsr_pkg::X_W-1:0]           tx;
    logic [tsr_pkg::Y_W-1:0]           ty;
    logic                              flat_bottom;
    logic                              flat_top;

    logic signed [tsr_pkg::DX_W-1:0]   dx;
    logic [tsr_pkg::Y_W-1:0]           dy;
    logic signed [tsr_pkg::NUM_W-1:0]  num;
    logic signed [tsr_pkg::NUM_W-1:0]  num_abs;
    logic [tsr_pkg::DEN_W-1:0]         den;
    logic                              div_done;
    logic signed [tsr_pkg::EDGE_W-1:0] div_q;

    logic [tsr_pkg::X_W-1:0]           xa;
    logic [tsr_pkg::X_W-1:0]           xb;
    logic [tsr_pkg::X_W-1:0]           left;
    logic [tsr_pkg::X_W-1:0]           right;
    logic                              at_end;

    // Sorting network by y: pairs 0-2, 0-1, 1-2; a pair swaps only when the first y is greater.
    always_comb
    begin
        tx = '0;
        ty = '0;
        for (int i = 0; i < 3; i++)
        begin
            sx[i] = vx_reg[i];
            sy[i] = vy_reg[i];
        end
        if (sy[0] > sy[2])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[2]; sy[0] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2])
        begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        flat_bottom = sy[1] == sy[2];
        flat_top    = sy[0] == sy[1];
    end

    // Divider operands for the job at hand.
    always_comb
    begin
        dx = '0;
        dy = '0;
        case (cmd.div_job)
            tsr_pkg::JOB_SPLIT:
            begin
                dx = tsr_pkg::xdiff(vx_reg[2], vx_reg[0]);
                dy = vy_reg[1] - vy_reg[0];
            end
            tsr_pkg::JOB_SLOPE1:
            begin
                case (kind_reg)
                    tsr_pkg::KIND_FT:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[2], vx_reg[0]);
                        dy = vy_reg[2] - vy_reg[0];
                    end
                    tsr_pkg::KIND_SPLIT_LO:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[2], vx_reg[1]);
                        dy = vy_reg[2] - vy_reg[1];
                    end
                    default:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[1], vx_reg[0]);
                        dy = vy_reg[1] - vy_reg[0];
                    end
                endcase
            end
            default:
            begin
                case (kind_reg)
                    tsr_pkg::KIND_FB:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[2], vx_reg[0]);
                        dy = vy_reg[2] - vy_reg[0];
                    end
                    tsr_pkg::KIND_FT:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[2], vx_reg[1]);
                        dy = vy_reg[2] - vy_reg[1];
                    end
                    tsr_pkg::KIND_SPLIT_UP:
                    begin
                        dx = tsr_pkg::xdiff(split_x_reg, vx_reg[0]);
                        dy = vy_reg[1] - vy_reg[0];
                    end
                    default:
                    begin
                        dx = tsr_pkg::xdiff(vx_reg[2], split_x_reg);
                        dy = vy_reg[2] - vy_reg[1];
                    end
                endcase
            end
        endcase

        if (cmd.div_job == tsr_pkg::JOB_SPLIT)
        begin
            // The split divides by the full height of the long edge.
            num = tsr_pkg::NUM_W'($signed({1'b0, dy}) * dx);
            den = tsr_pkg::DEN_W'(vy_reg[2] - vy_reg[0]);
        end
        else
        begin
            // Rounded slope: floor((2*dx*2^F + dy) / (2*dy)).
            num = (tsr_pkg::NUM_W'(dx) <<< (tsr_pkg::FRAC_W + 1))
                + $signed(tsr_pkg::NUM_W'(dy));
            den = tsr_pkg::DEN_W'({dy, 1'b0});
        end
        num_abs = num[tsr_pkg::NUM_W-1] ? -num : num;
    end

    tsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .neg      (num[tsr_pkg::NUM_W-1]),
        .mag      (num_abs[tsr_pkg::MAG_W-1:0]),
        .den      (den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Span of the current row.
    always_comb
    begin
        xa     = tsr_pkg::span_x(edge_l_reg);
        xb     = tsr_pkg::span_x(edge_r_reg);
        left   = (xa > xb) ? xb : xa;
        right  = (xa > xb) ? xa : xb;
        at_end = cur_row_reg == end_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            split_x_reg   <= '0;
            edge_l_reg    <= '0;
            edge_r_reg    <= '0;
            slope1_reg    <= '0;
            slope2_reg    <= '0;
            cur_row_reg   <= '0;
            end_row_reg   <= '0;
            colour_reg    <= '0;
            phase_reg     <= tsr_pkg::PH_IDLE;
            kind_reg      <= tsr_pkg::KIND_FB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.load)
            begin
                vx_reg[0]  <= in_data.ax;
                vy_reg[0]  <= in_data.ay;
                vx_reg[1]  <= in_data.bx;
                vy_reg[1]  <= in_data.by_coord;
                vx_reg[2]  <= in_data.cx;
                vy_reg[2]  <= in_data.cy;
                colour_reg <= in_data.fill_colour;
                phase_reg  <= tsr_pkg::PH_IDLE;
            end

            if (cmd.classify)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vx_reg[i] <= sx[i];
                    vy_reg[i] <= sy[i];
                end
                split_x_reg <= '0;
                edge_l_reg  <= $signed(tsr_pkg::EDGE_W'({sx[0], {tsr_pkg::FRAC_W{1'b0}}}));
                cur_row_reg <= sy[0];
                if (flat_bottom)
                begin
                    edge_r_reg  <= $signed(tsr_pkg::EDGE_W'({sx[0], {tsr_pkg::FRAC_W{1'b0}}}));
                    end_row_reg <= sy[1];
                    kind_reg    <= tsr_pkg::KIND_FB;
                    phase_reg   <= tsr_pkg::PH_SINGLE;
                end
                else if (flat_top)
                begin
                    edge_r_reg  <= $signed(tsr_pkg::EDGE_W'({sx[1], {tsr_pkg::FRAC_W{1'b0}}}));
                    end_row_reg <= sy[2];
                    kind_reg    <= tsr_pkg::KIND_FT;
                    phase_reg   <= tsr_pkg::PH_SINGLE;
                end
                else
                begin
                    edge_r_reg  <= $signed(tsr_pkg::EDGE_W'({sx[0], {tsr_pkg::FRAC_W{1'b0}}}));
                    end_row_reg <= sy[1];
                    kind_reg    <= tsr_pkg::KIND_SPLIT_UP;
                    phase_reg   <= tsr_pkg::PH_UPPER;
                end
            end

            if (cmd.store)
            begin
                case (cmd.div_job)
                    tsr_pkg::JOB_SPLIT:  split_x_reg <= vx_reg[0] + div_q[tsr_pkg::X_W-1:0];
                    tsr_pkg::JOB_SLOPE1: slope1_reg  <= div_q;
                    default:             slope2_reg  <= div_q;
                endcase
            end

            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
                if (phase_reg != tsr_pkg::PH_IDLE)
                begin
                    if (at_end)
                    begin
                        if (phase_reg == tsr_pkg::PH_UPPER)
                        begin
                            // Lower half starts again on the middle row.
                            edge_l_reg  <= $signed(tsr_pkg::EDGE_W'(
                                               {vx_reg[1], {tsr_pkg::FRAC_W{1'b0}}}));
                            edge_r_reg  <= $signed(tsr_pkg::EDGE_W'(
                                               {split_x_reg, {tsr_pkg::FRAC_W{1'b0}}}));
                            cur_row_reg <= vy_reg[1];
                            end_row_reg <= vy_reg[2];
                            kind_reg    <= tsr_pkg::KIND_SPLIT_LO;
                            phase_reg   <= tsr_pkg::PH_LOWER;
                        end
                        else
                        begin
                            phase_reg <= tsr_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        cur_row_reg <= cur_row_reg + 1'b1;
                        edge_l_reg  <= edge_l_reg + slope1_reg;
                        edge_r_reg  <= edge_r_reg + slope2_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            if (phase_reg == tsr_pkg::PH_IDLE)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg.span_row    <= cur_row_reg;
                out_data_reg.span_left   <= left;
                out_data_reg.span_right  <= right;
                out_data_reg.span_colour <= colour_reg;
                out_data_reg.span_valid  <= 1'b1;
                out_data_reg.last_span   <= at_end &&
                                            (phase_reg == tsr_pkg::PH_SINGLE ||
                                             phase_reg == tsr_pkg::PH_LOWER);
            end
        end
    end

    assign status.is_split    = !flat_bottom && !flat_top;
    assign status.enter_lower = (phase_reg == tsr_pkg::PH_UPPER) && at_end;
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/tsr_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// tsr_ctrl
// Sequencer for load and step transfers and triangle setup: sort, split point and the two slope divisions.
// ============================================================================
module tsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  tsr_pkg::status_t  status,
    output tsr_pkg::cmd_t     cmd
);

    tsr_pkg::state_t state_reg;
    tsr_pkg::state_t state_next;
    logic            accept;

    assign in_ready = (state_reg == tsr_pkg::ST_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tsr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (accept && opcode == tsr_pkg::OP_LOAD)
                    state_next = tsr_pkg::ST_SORT;
                else if (accept && status.enter_lower)
                    state_next = tsr_pkg::ST_S1_START;
            end
            tsr_pkg::ST_SORT:
                state_next = status.is_split ? tsr_pkg::ST_SPLIT_START
                                             : tsr_pkg::ST_S1_START;
            tsr_pkg::ST_SPLIT_START:
                state_next = tsr_pkg::ST_SPLIT_WAIT;
            tsr_pkg::ST_SPLIT_WAIT:
                if (status.div_done)
                    state_next = tsr_pkg::ST_S1_START;
            tsr_pkg::ST_S1_START:
                state_next = tsr_pkg::ST_S1_WAIT;
            tsr_pkg::ST_S1_WAIT:
                if (status.div_done)
                    state_next = tsr_pkg::ST_S2_START;
            tsr_pkg::ST_S2_START:
                state_next = tsr_pkg::ST_S2_WAIT;
            tsr_pkg::ST_S2_WAIT:
                if (status.div_done)
                    state_next = tsr_pkg::ST_IDLE;
            default:
                state_next = tsr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_job  = tsr_pkg::JOB_SLOPE1;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                cmd.load = accept && opcode == tsr_pkg::OP_LOAD;
                cmd.step = accept && opcode == tsr_pkg::OP_STEP;
            end
            tsr_pkg::ST_SORT:
                cmd.classify = 1'b1;
            tsr_pkg::ST_SPLIT_START:
            begin
                cmd.div_job   = tsr_pkg::JOB_SPLIT;
                cmd.div_start = 1'b1;
            end
            tsr_pkg::ST_SPLIT_WAIT:
            begin
                cmd.div_job = tsr_pkg::JOB_SPLIT;
                cmd.store   = status.div_done;
            end
            tsr_pkg::ST_S1_START:
                cmd.div_start = 1'b1;
            tsr_pkg::ST_S1_WAIT:
                cmd.store = status.div_done;
            tsr_pkg::ST_S2_START:
            begin
                cmd.div_job   = tsr_pkg::JOB_SLOPE2;
                cmd.div_start = 1'b1;
            end
            tsr_pkg::ST_S2_WAIT:
            begin
                cmd.div_job = tsr_pkg::JOB_SLOPE2;
                cmd.store   = status.div_done;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule
